### src/rsltrk_pkg.sv
`default_nettype none

package rsltrk_pkg;

    localparam int SEQ_LEN = 8;
    localparam int TABLE_W = 8 * SEQ_LEN;

    localparam logic [1:0] DIR_NONE   = 2'd0;
    localparam logic [1:0] DIR_LOWER  = 2'd1;
    localparam logic [1:0] DIR_HIGHER = 2'd2;

    localparam logic [7:0]  SPEED_RESET = 8'd128;
    localparam logic [7:0]  SPEED_SLOW  = 8'd64;
    localparam logic [31:0] GAP_LIMIT   = 32'd300;

    typedef struct packed {
        logic [7:0]  key_state;
        logic [31:0] tick_now;
    } sample_t;

    typedef struct packed {
        logic [3:0] position;
        logic [1:0] direction;
        logic [7:0] abs_speed;
    } result_t;

endpackage

`default_nettype wire

### src/rsltrk_match.sv
`default_nettype none

module rsltrk_match (
    input  wire logic [rsltrk_pkg::TABLE_W-1:0] seq_table,
    input  wire logic [7:0]                     key_state,
    output logic [3:0]                          position
);

    logic [rsltrk_pkg::SEQ_LEN-1:0] active;
    logic [7:0]                     mask;
    logic [7:0]                     key_masked;

    // a byte is in the list only if it and every byte below it are nonzero
    always_comb
    begin
        active = '0;
        mask   = '0;
        for (int i = 0; i < rsltrk_pkg::SEQ_LEN; i++)
        begin
            if (i == 0)
            begin
                active[i] = (seq_table[7:0] != 8'd0);
            end
            else
            begin
                active[i] = active[i-1] && (seq_table[8*i +: 8] != 8'd0);
            end
            if (active[i])
            begin
                mask = mask | seq_table[8*i +: 8];
            end
        end
    end

    assign key_masked = key_state & mask;

    // active bytes are nonzero, so a zero masked key never matches; lowest index wins
    always_comb
    begin
        position = 4'd0;
        for (int i = rsltrk_pkg::SEQ_LEN - 1; i >= 0; i--)
        begin
            if (active[i] && (key_masked == seq_table[8*i +: 8]))
            begin
                position = 4'(i + 1);
            end
        end
    end

endmodule

`default_nettype wire

### src/rsltrk_motion.sv
`default_nettype none

module rsltrk_motion (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire logic [3:0]          position,
    input  wire logic [31:0]         tick_now,
    output rsltrk_pkg::result_t      result_next
);

    logic [3:0]  last_pos_reg,  last_pos_next;
    logic [31:0] last_tick_reg, last_tick_next;
    logic [1:0]  dir_reg,       dir_next;
    logic [7:0]  speed_reg,     speed_next;
    logic [31:0] gap;

    assign gap = tick_now - last_tick_reg;

    always_comb
    begin
        last_pos_next  = last_pos_reg;
        last_tick_next = last_tick_reg;
        dir_next       = dir_reg;
        speed_next     = speed_reg;
        if (position != last_pos_reg)
        begin
            if ((last_pos_reg != 4'd0) && (position != 4'd0))
            begin
                dir_next = (position > last_pos_reg) ? rsltrk_pkg::DIR_HIGHER
                                                     : rsltrk_pkg::DIR_LOWER;
                speed_next = (gap > rsltrk_pkg::GAP_LIMIT) ? rsltrk_pkg::SPEED_SLOW
                                                           : gap[10:3];
            end
            if (position != 4'd0)
            begin
                last_tick_next = tick_now;
            end
            // fresh press from released
            if (last_pos_reg == 4'd0)
            begin
                speed_next = rsltrk_pkg::SPEED_SLOW;
            end
            last_pos_next = position;
        end
    end

    assign result_next.position  = last_pos_next;
    assign result_next.direction = dir_next;
    assign result_next.abs_speed = speed_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pos_reg  <= 4'd0;
            last_tick_reg <= 32'd0;
            dir_reg       <= rsltrk_pkg::DIR_NONE;
            speed_reg     <= rsltrk_pkg::SPEED_RESET;
        end
        else if (step)
        begin
            last_pos_reg  <= last_pos_next;
            last_tick_reg <= last_tick_next;
            dir_reg       <= dir_next;
            speed_reg     <= speed_next;
        end
    end

endmodule

`default_nettype wire

### src/roll_slider_tracker_core.sv
// roll_slider_tracker_core
// Channels: sample (key_state, tick_now) in, result (position, direction,
// abs_speed) out, both valid/ready; a transaction completes when valid and
// ready are both high at a rising edge. cfg_data writes the 64-bit sequence
// table (eight key-pattern bytes, lowest first) and is taken in every cycle;
// write it only while no sample transaction is in flight.
// A sample accepted at a rising edge lands in the input register; its result
// is loaded into the result register when that register is empty or its
// contents are being taken.
// Throughput: one sample per cycle unless result stalls, set by the single
// compare-and-update pass between the input register and result register.
// Reset clears the sequence table, both stage valid flags and the tracking
// state (released, no direction, speed 128).
// When the receiver stalls, the result register holds, the input register
// fills if empty and holds, and sample_ready drops until result is taken.
`default_nettype none

module roll_slider_tracker_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        sample_valid,
    output logic                             sample_ready,
    input  wire rsltrk_pkg::sample_t         sample,
    output logic                             result_valid,
    input  wire logic                        result_ready,
    output rsltrk_pkg::result_t              result,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [rsltrk_pkg::TABLE_W-1:0] cfg_data
);

    logic [rsltrk_pkg::TABLE_W-1:0] table_reg;
    rsltrk_pkg::sample_t            in_reg;
    logic                           in_valid_reg;
    rsltrk_pkg::result_t            out_reg;
    logic                           out_valid_reg;
    logic                           advance;
    logic [3:0]                     position;
    rsltrk_pkg::result_t            result_next;

    assign cfg_ready    = 1'b1;
    assign advance      = in_valid_reg && (!out_valid_reg || result_ready);
    assign sample_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_reg <= '0;
        end
        else if (cfg_valid)
        begin
            table_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample_ready)
        begin
            in_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_ready && sample_valid)
        begin
            in_reg <= sample;
        end
    end

    rsltrk_match u_match (
        .seq_table (table_reg),
        .key_state (in_reg.key_state),
        .position  (position)
    );

    rsltrk_motion u_motion (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .position    (position),
        .tick_now    (in_reg.tick_now),
        .result_next (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

### src/rsltrk_checker.sv
`default_nettype none

module rsltrk_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                sample_valid,
    input wire logic                sample_ready,
    input wire logic                result_valid,
    input wire logic                result_ready,
    input wire rsltrk_pkg::result_t result
);

    // a stalled result transaction holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.position <= 4'(rsltrk_pkg::SEQ_LEN))
    else $error("position beyond sequence length");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.direction != 2'd3)
    else $error("invalid direction code");

    // once pressed, speed is either the slow value or a short gap scaled down
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.position != 4'd0 |-> result.abs_speed <= rsltrk_pkg::SPEED_SLOW)
    else $error("speed out of range while pressed");

    // with both stages full, a new sample is taken only when the result drains
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready && sample_valid && sample_ready
        |=> !sample_ready || result_ready)
    else $error("sample accepted with both stages full");

endmodule

bind roll_slider_tracker_core rsltrk_checker u_rsltrk_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire
